### rtl/lwbc_pkg.sv
`default_nettype none

package lwbc_pkg;

  // Command codes of an input transaction.
  localparam logic [2:0] CMD_ACCESS    = 3'd0;
  localparam logic [2:0] CMD_RELEASE   = 3'd1;
  localparam logic [2:0] CMD_MARK      = 3'd2;
  localparam logic [2:0] CMD_FLUSH_ALL = 3'd3;
  localparam logic [2:0] CMD_FLUSH_LRU = 3'd4;

  // Result kinds.
  localparam logic [2:0] KIND_HIT  = 3'd0;
  localparam logic [2:0] KIND_MISS = 3'd1;
  localparam logic [2:0] KIND_WB   = 3'd2;
  localparam logic [2:0] KIND_DONE = 3'd3;
  localparam logic [2:0] KIND_ERR  = 3'd4;

  typedef logic [3:0] act_t;

  // Datapath actions issued by the controller.
  localparam act_t ACT_IDLE      = 4'd0;
  localparam act_t ACT_LOAD      = 4'd1;
  localparam act_t ACT_ERR       = 4'd2;
  localparam act_t ACT_HIT       = 4'd3;
  localparam act_t ACT_MISS      = 4'd4;
  localparam act_t ACT_ALLOC     = 4'd5;
  localparam act_t ACT_RELEASE   = 4'd6;
  localparam act_t ACT_MARK      = 4'd7;
  localparam act_t ACT_FLUSH_ALL = 4'd8;
  localparam act_t ACT_FLUSH_LRU = 4'd9;
  localparam act_t ACT_COUNT     = 4'd10;
  localparam act_t ACT_WALK      = 4'd11;
  localparam act_t ACT_DONE      = 4'd12;

  typedef struct packed {
    act_t act;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       addr_zero;
    logic       hit;
    logic       victim_dirty;
    logic       rel_ok;
    logic       mark_ok;
    logic       flush_empty;
    logic       step_last;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/lru_write_back_node_cache_top.sv
// Channel   Direction  Handshake                   Payload
// input     in         start high, busy low        in_cmd, in_node_address, in_load_wanted,
//                                                  in_slot, in_flush_count
// result    out        out_strobe, one cycle each  out_kind, out_slot_index, out_address_out,
//                                                  out_read_needed, out_dirty_total, out_last
//
// Access, release, mark dirty and errors first take the command, then do the parallel
// tag compare and the directory update. A miss on a dirty slot gives a second result: the
// writeback first, then the allocation. Flush all walks every slot in recency order; a flush
// of k least recent slots (k capped at SLOTS), when k is above zero, walks the recency order
// twice at one slot per cycle (count, then write back), and goes straight to done at k zero.
// Reset is synchronous and clears the directory; results are never stalled.
`default_nettype none

module lru_write_back_node_cache_top #(
  parameter int SLOTS     = 16,
  parameter int ADDR_BITS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire [2:0]   in_cmd,
  input  wire [31:0]  in_node_address,
  input  wire         in_load_wanted,
  input  wire [3:0]   in_slot,
  input  wire [4:0]   in_flush_count,
  output logic        out_strobe,
  output logic [2:0]  out_kind,
  output logic [3:0]  out_slot_index,
  output logic [31:0] out_address_out,
  output logic        out_read_needed,
  output logic [4:0]  out_dirty_total,
  output logic        out_last
);
  import lwbc_pkg::*;

  ctl_cmd_t   ctl;
  dp_status_t status;

  lwbc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .ctl    (ctl)
  );

  lwbc_datapath #(
    .SLOTS     (SLOTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .status          (status),
    .in_cmd          (in_cmd),
    .in_node_address (in_node_address),
    .in_load_wanted  (in_load_wanted),
    .in_slot         (in_slot),
    .in_flush_count  (in_flush_count),
    .out_strobe      (out_strobe),
    .out_kind        (out_kind),
    .out_slot_index  (out_slot_index),
    .out_address_out (out_address_out),
    .out_read_needed (out_read_needed),
    .out_dirty_total (out_dirty_total),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

### rtl/lwbc_datapath.sv
`default_nettype none

module lwbc_datapath #(
  parameter int SLOTS     = 16,
  parameter int ADDR_BITS = 32
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  lwbc_pkg::ctl_cmd_t      ctl,
  output lwbc_pkg::dp_status_t    status,
  input  wire [2:0]               in_cmd,
  input  wire [31:0]              in_node_address,
  input  wire                     in_load_wanted,
  input  wire [3:0]               in_slot,
  input  wire [4:0]               in_flush_count,
  output logic                    out_strobe,
  output logic [2:0]              out_kind,
  output logic [3:0]              out_slot_index,
  output logic [31:0]             out_address_out,
  output logic                    out_read_needed,
  output logic [4:0]              out_dirty_total,
  output logic                    out_last
);
  import lwbc_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [SW-1:0] LAST_RANK = SW'(SLOTS - 1);
  localparam logic [CW-1:0] SLOTS_C   = CW'(SLOTS);

  // Latched transaction fields.
  logic [2:0]           cmd_q_r;
  logic [ADDR_BITS-1:0] addr_q_r;
  logic                 load_q_r;
  logic [3:0]           slot_q_r;
  logic [4:0]           cnt_q_r;

  // Directory state.
  logic [ADDR_BITS-1:0] tag_r   [SLOTS];
  logic [ADDR_BITS-1:0] tag_nxt [SLOTS];
  logic [SW-1:0]        rank_r  [SLOTS];
  logic [SW-1:0]        rank_nxt[SLOTS];
  logic [SLOTS-1:0]     dirty_r, dirty_nxt;
  logic [CW-1:0]        dcnt_r, dcnt_nxt;

  // Walk state for the flush commands.
  logic [SW-1:0]        ptr_r, ptr_nxt;
  logic [CW-1:0]        remain_r, remain_nxt;
  logic                 up_r, up_nxt;
  logic [CW-1:0]        acc_r, acc_nxt;
  logic [CW-1:0]        final_r, final_nxt;
  logic [SW-1:0]        victim_q_r, victim_q_nxt;

  // Output registers.
  logic                 strobe_r, strobe_nxt;
  logic [2:0]           kind_r, kind_nxt;
  logic [3:0]           oslot_r, oslot_nxt;
  logic [31:0]          oaddr_r, oaddr_nxt;
  logic                 ord_r, ord_nxt;
  logic [4:0]           odt_r, odt_nxt;
  logic                 olast_r, olast_nxt;

  // Lookup results.
  logic [ADDR_BITS+31:0] addr_wide;
  logic [SW+3:0]         slot_ext;
  logic                  slot_ok;
  logic [SW-1:0]         slot_idx;
  logic [CW+4:0]         cnt_ext;
  logic [CW-1:0]         flush_k;
  logic [SLOTS-1:0]      match;
  logic [SW-1:0]         hit_slot, victim, ptr_slot, prom_slot, prom_rank, dem_rank;
  logic                  hit, victim_dirty, ptr_dirty;
  logic [CW-1:0]         acc_step;

  // Emitted values before resizing to the port widths.
  logic [SW-1:0]         emit_slot;
  logic [ADDR_BITS-1:0]  emit_addr;
  logic [CW-1:0]         emit_dt;
  logic [SW+3:0]         slot_wide;
  logic [ADDR_BITS+31:0] emit_addr_wide;
  logic [CW+4:0]         dt_wide;

  assign addr_wide = {{ADDR_BITS{1'b0}}, in_node_address};
  assign slot_ext  = {{SW{1'b0}}, slot_q_r};
  assign slot_ok   = slot_ext < (SW + 4)'(SLOTS);
  assign slot_idx  = slot_ext[SW-1:0];
  assign cnt_ext   = {{CW{1'b0}}, cnt_q_r};
  assign flush_k   = (cnt_ext > (CW + 5)'(SLOTS)) ? SLOTS_C : cnt_ext[CW-1:0];

  // Parallel tag compare and rank decode. Tags and ranks are unique, so the
  // matches are one-hot and an OR encoder suffices.
  always_comb begin
    match    = '0;
    hit_slot = '0;
    victim   = '0;
    ptr_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = tag_r[i] == addr_q_r;
      if (match[i]) hit_slot = hit_slot | SW'(i);
      if (rank_r[i] == LAST_RANK) victim = victim | SW'(i);
      if (rank_r[i] == ptr_r) ptr_slot = ptr_slot | SW'(i);
    end
  end

  assign hit          = |match;
  assign victim_dirty = dirty_r[victim] && (tag_r[victim] != '0);
  assign ptr_dirty    = dirty_r[ptr_slot] && (tag_r[ptr_slot] != '0);
  assign prom_slot    = (ctl.act == ACT_HIT) ? hit_slot : victim;
  assign prom_rank    = rank_r[prom_slot];
  assign dem_rank     = rank_r[slot_idx];
  assign acc_step     = acc_r + CW'(ptr_dirty);

  always_comb begin
    status.cmd          = cmd_q_r;
    status.addr_zero    = addr_q_r == '0;
    status.hit          = hit;
    status.victim_dirty = victim_dirty;
    status.rel_ok       = slot_ok && (addr_q_r != '0) && (tag_r[slot_idx] == addr_q_r);
    status.mark_ok      = slot_ok && (tag_r[slot_idx] != '0);
    status.flush_empty  = cnt_q_r == 5'd0;
    status.step_last    = remain_r == CW'(1);
  end

  always_comb begin
    tag_nxt      = tag_r;
    rank_nxt     = rank_r;
    dirty_nxt    = dirty_r;
    dcnt_nxt     = dcnt_r;
    ptr_nxt      = ptr_r;
    remain_nxt   = remain_r;
    up_nxt       = up_r;
    acc_nxt      = acc_r;
    final_nxt    = final_r;
    victim_q_nxt = victim_q_r;
    strobe_nxt   = 1'b0;
    kind_nxt     = kind_r;
    ord_nxt      = 1'b0;
    olast_nxt    = 1'b0;
    emit_slot    = '0;
    emit_addr    = '0;
    emit_dt      = dcnt_r;

    unique case (ctl.act)
      ACT_ERR: begin
        strobe_nxt = 1'b1;
        kind_nxt   = KIND_ERR;
        olast_nxt  = 1'b1;
      end
      ACT_HIT: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (rank_r[i] < prom_rank) rank_nxt[i] = rank_r[i] + SW'(1);
        end
        rank_nxt[prom_slot] = '0;
        strobe_nxt = 1'b1;
        kind_nxt   = KIND_HIT;
        emit_slot  = hit_slot;
        emit_addr  = addr_q_r;
        olast_nxt  = 1'b1;
      end
      ACT_MISS: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (rank_r[i] < prom_rank) rank_nxt[i] = rank_r[i] + SW'(1);
        end
        rank_nxt[prom_slot] = '0;
        tag_nxt[victim]     = addr_q_r;
        dirty_nxt[victim]   = 1'b0;
        victim_q_nxt        = victim;
        strobe_nxt          = 1'b1;
        emit_slot           = victim;
        if (victim_dirty) begin
          // The old tag goes out first; the allocation follows next cycle.
          dcnt_nxt  = dcnt_r - CW'(1);
          emit_dt   = dcnt_nxt;
          kind_nxt  = KIND_WB;
          emit_addr = tag_r[victim];
        end else begin
          kind_nxt  = KIND_MISS;
          emit_addr = addr_q_r;
          ord_nxt   = load_q_r;
          olast_nxt = 1'b1;
        end
      end
      ACT_ALLOC: begin
        strobe_nxt = 1'b1;
        kind_nxt   = KIND_MISS;
        emit_slot  = victim_q_r;
        emit_addr  = addr_q_r;
        ord_nxt    = load_q_r;
        olast_nxt  = 1'b1;
      end
      ACT_RELEASE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (rank_r[i] > dem_rank) rank_nxt[i] = rank_r[i] - SW'(1);
        end
        rank_nxt[slot_idx]  = LAST_RANK;
        tag_nxt[slot_idx]   = '0;
        dirty_nxt[slot_idx] = 1'b0;
        dcnt_nxt   = dcnt_r - CW'(dirty_r[slot_idx]);
        emit_dt    = dcnt_nxt;
        strobe_nxt = 1'b1;
        kind_nxt   = KIND_DONE;
        emit_slot  = slot_idx;
        olast_nxt  = 1'b1;
      end
      ACT_MARK: begin
        dirty_nxt[slot_idx] = 1'b1;
        dcnt_nxt   = dcnt_r + CW'(!dirty_r[slot_idx]);
        emit_dt    = dcnt_nxt;
        strobe_nxt = 1'b1;
        kind_nxt   = KIND_DONE;
        emit_slot  = slot_idx;
        emit_addr  = tag_r[slot_idx];
        olast_nxt  = 1'b1;
      end
      ACT_FLUSH_ALL: begin
        // Every dirty slot gets written back, so nothing stays dirty.
        ptr_nxt    = '0;
        remain_nxt = SLOTS_C;
        up_nxt     = 1'b1;
        final_nxt  = '0;
      end
      ACT_FLUSH_LRU: begin
        ptr_nxt    = LAST_RANK;
        remain_nxt = flush_k;
        up_nxt     = 1'b0;
        acc_nxt    = '0;
      end
      ACT_COUNT: begin
        // First pass: count the dirty slots the walk will write back, so every
        // writeback can carry the final dirty total.
        acc_nxt = acc_step;
        if (remain_r == CW'(1)) begin
          final_nxt  = dcnt_r - acc_step;
          ptr_nxt    = LAST_RANK;
          remain_nxt = flush_k;
        end else begin
          ptr_nxt    = ptr_r - SW'(1);
          remain_nxt = remain_r - CW'(1);
        end
      end
      ACT_WALK: begin
        if (ptr_dirty) begin
          tag_nxt[ptr_slot]   = '0;
          dirty_nxt[ptr_slot] = 1'b0;
          dcnt_nxt   = dcnt_r - CW'(1);
          strobe_nxt = 1'b1;
          kind_nxt   = KIND_WB;
          emit_slot  = ptr_slot;
          emit_addr  = tag_r[ptr_slot];
          emit_dt    = final_r;
        end
        ptr_nxt    = up_r ? ptr_r + SW'(1) : ptr_r - SW'(1);
        remain_nxt = remain_r - CW'(1);
      end
      ACT_DONE: begin
        strobe_nxt = 1'b1;
        kind_nxt   = KIND_DONE;
        olast_nxt  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign slot_wide      = {4'd0, emit_slot};
  assign emit_addr_wide = {32'd0, emit_addr};
  assign dt_wide        = {5'd0, emit_dt};
  assign oslot_nxt      = slot_wide[3:0];
  assign oaddr_nxt      = emit_addr_wide[31:0];
  assign odt_nxt        = dt_wide[4:0];

  always_ff @(posedge clk) begin
    if (ctl.act == ACT_LOAD) begin
      cmd_q_r  <= in_cmd;
      addr_q_r <= addr_wide[ADDR_BITS-1:0];
      load_q_r <= in_load_wanted;
      slot_q_r <= in_slot;
      cnt_q_r  <= in_flush_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        tag_r[i]  <= '0;
        rank_r[i] <= SW'(i);
      end
      dirty_r    <= '0;
      dcnt_r     <= '0;
      ptr_r      <= '0;
      remain_r   <= '0;
      up_r       <= 1'b0;
      acc_r      <= '0;
      final_r    <= '0;
      victim_q_r <= '0;
      strobe_r   <= 1'b0;
    end else begin
      tag_r      <= tag_nxt;
      rank_r     <= rank_nxt;
      dirty_r    <= dirty_nxt;
      dcnt_r     <= dcnt_nxt;
      ptr_r      <= ptr_nxt;
      remain_r   <= remain_nxt;
      up_r       <= up_nxt;
      acc_r      <= acc_nxt;
      final_r    <= final_nxt;
      victim_q_r <= victim_q_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (strobe_nxt) begin
      kind_r  <= kind_nxt;
      oslot_r <= oslot_nxt;
      oaddr_r <= oaddr_nxt;
      ord_r   <= ord_nxt;
      odt_r   <= odt_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_kind        = kind_r;
  assign out_slot_index  = oslot_r;
  assign out_address_out = oaddr_r;
  assign out_read_needed = ord_r;
  assign out_dirty_total = odt_r;
  assign out_last        = olast_r;

endmodule

`default_nettype wire

### rtl/lwbc_ctrl.sv
`default_nettype none

module lwbc_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  lwbc_pkg::dp_status_t   status,
  output lwbc_pkg::ctl_cmd_t     ctl
);
  import lwbc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_COUNT = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl.act   = ACT_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.act   = ACT_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (status.cmd)
          CMD_ACCESS: begin
            if (status.addr_zero) begin
              ctl.act = ACT_ERR;
            end else if (status.hit) begin
              ctl.act = ACT_HIT;
            end else begin
              ctl.act = ACT_MISS;
              if (status.victim_dirty) state_nxt = S_ALLOC;
            end
          end
          CMD_RELEASE: ctl.act = status.rel_ok ? ACT_RELEASE : ACT_ERR;
          CMD_MARK:    ctl.act = status.mark_ok ? ACT_MARK : ACT_ERR;
          CMD_FLUSH_ALL: begin
            ctl.act   = ACT_FLUSH_ALL;
            state_nxt = S_WALK;
          end
          CMD_FLUSH_LRU: begin
            if (status.flush_empty) begin
              ctl.act = ACT_DONE;
            end else begin
              ctl.act   = ACT_FLUSH_LRU;
              state_nxt = S_COUNT;
            end
          end
          default: ctl.act = ACT_ERR;
        endcase
      end
      S_ALLOC: begin
        ctl.act   = ACT_ALLOC;
        state_nxt = S_IDLE;
      end
      S_COUNT: begin
        ctl.act = ACT_COUNT;
        if (status.step_last) state_nxt = S_WALK;
      end
      S_WALK: begin
        ctl.act = ACT_WALK;
        if (status.step_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        ctl.act   = ACT_DONE;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

`default_nettype wire

### rtl/lwbc_checker.sv
`default_nettype none

module lwbc_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire        out_strobe,
  input wire [2:0]  out_kind,
  input wire [3:0]  out_slot_index,
  input wire [31:0] out_address_out,
  input wire [4:0]  out_dirty_total,
  input wire        out_last
);
  import lwbc_pkg::*;

  // A taken transaction keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after a transaction was taken");

  // The block goes idle exactly when the final result of a transaction shows.
  a_idle_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_strobe && out_last)
    else $error("block went idle without a final result");

  // More results are still owed after a non-final one.
  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |-> busy)
    else $error("non-final result while the block is idle");

  // All results of one transaction report the same dirty total.
  a_total_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=>
      !out_strobe || (out_dirty_total == $past(out_dirty_total)))
    else $error("dirty total changed within a transaction");

  // An error is a single result with no slot and no address.
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_kind == KIND_ERR) |->
      out_last && (out_slot_index == 4'd0) && (out_address_out == 32'd0))
    else $error("malformed error result");

endmodule

bind lru_write_back_node_cache_top lwbc_checker u_lwbc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_kind        (out_kind),
  .out_slot_index  (out_slot_index),
  .out_address_out (out_address_out),
  .out_dirty_total (out_dirty_total),
  .out_last        (out_last)
);

`default_nettype wire

### verif/lwbc_result_checker.sv
`timescale 1ns / 1ps

module lwbc_result_checker (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire                busy,
  input  wire [2:0]          in_cmd,
  input  wire [31:0]         in_node_address,
  input  wire                in_load_wanted,
  input  wire [3:0]          in_slot,
  input  wire [4:0]          in_flush_count,
  input  wire                out_strobe,
  input  wire [2:0]          out_kind,
  input  wire [3:0]          out_slot_index,
  input  wire [31:0]         out_address_out,
  input  wire                out_read_needed,
  input  wire [4:0]          out_dirty_total,
  input  wire                out_last,
  output int                 fail_count,
  output int                 outstanding,
  output logic [15:0][31:0]  slot_tags
);
  import lwbc_pkg::*;

  localparam int NSLOTS = 16;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot_index;
    logic [31:0] address_out;
    logic        read_needed;
    logic [4:0]  dirty_total;
    logic        last;
  } cache_result_t;

  logic [31:0] tag_of   [NSLOTS];
  bit          dirty_of [NSLOTS];
  logic [3:0]  rank_of  [NSLOTS];

  cache_result_t step_responses[$];
  cache_result_t cache_responses[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    slot_tags   = '0;
  end

  task automatic clear_directory();
    for (int i = 0; i < NSLOTS; i++) begin
      tag_of[i]   = '0;
      dirty_of[i] = 1'b0;
      rank_of[i]  = 4'(i);
    end
  endtask

  task automatic add_response(input logic [2:0] kind, input int slot, input logic [31:0] addr,
                              input logic rd);
    cache_result_t r;
    r             = '0;
    r.kind        = kind;
    r.slot_index  = 4'(slot);
    r.address_out = addr;
    r.read_needed = rd;
    step_responses.push_back(r);
  endtask

  function automatic int slot_at_rank(input int rank);
    for (int i = 0; i < NSLOTS; i++)
      if (rank_of[i] == 4'(rank)) return i;
    return 0;
  endfunction

  task automatic make_most_recent(input int s);
    logic [3:0] r;
    r = rank_of[s];
    for (int i = 0; i < NSLOTS; i++)
      if (rank_of[i] < r) rank_of[i] = rank_of[i] + 4'd1;
    rank_of[s] = '0;
  endtask

  task automatic make_least_recent(input int s);
    logic [3:0] r;
    r = rank_of[s];
    for (int i = 0; i < NSLOTS; i++)
      if (rank_of[i] > r) rank_of[i] = rank_of[i] - 4'd1;
    rank_of[s] = 4'(NSLOTS - 1);
  endtask

  task automatic write_back_slot(input int s);
    if (dirty_of[s] && tag_of[s] != '0) begin
      add_response(KIND_WB, s, tag_of[s], 1'b0);
      tag_of[s]   = '0;
      dirty_of[s] = 1'b0;
    end
  endtask

  // Applies one accepted transaction to the directory and queues every result it causes.
  task automatic directory_step(input logic [2:0] cmd, input logic [31:0] addr,
                                input logic load, input logic [3:0] slot,
                                input logic [4:0] cnt);
    bit   hit;
    int   s;
    int   visits;
    int   dirty_count;
    cache_result_t r;
    hit = 0;
    s   = 0;
    step_responses.delete();
    case (cmd)
      CMD_ACCESS: begin
        if (addr == '0) begin
          add_response(KIND_ERR, 0, '0, 1'b0);
        end else begin
          for (int i = 0; i < NSLOTS; i++) begin
            if (!hit && tag_of[i] == addr) begin
              hit = 1;
              s   = i;
            end
          end
          if (hit) begin
            make_most_recent(s);
            add_response(KIND_HIT, s, addr, 1'b0);
          end else begin
            s = slot_at_rank(NSLOTS - 1);
            write_back_slot(s);
            tag_of[s]   = addr;
            dirty_of[s] = 1'b0;
            make_most_recent(s);
            add_response(KIND_MISS, s, addr, load);
          end
        end
      end
      CMD_RELEASE: begin
        if (addr != '0 && tag_of[slot] == addr) begin
          tag_of[slot]   = '0;
          dirty_of[slot] = 1'b0;
          make_least_recent(int'(slot));
          add_response(KIND_DONE, int'(slot), '0, 1'b0);
        end else begin
          add_response(KIND_ERR, 0, '0, 1'b0);
        end
      end
      CMD_MARK: begin
        if (tag_of[slot] != '0) begin
          dirty_of[slot] = 1'b1;
          add_response(KIND_DONE, int'(slot), tag_of[slot], 1'b0);
        end else begin
          add_response(KIND_ERR, 0, '0, 1'b0);
        end
      end
      CMD_FLUSH_ALL: begin
        for (int rank = 0; rank < NSLOTS; rank++)
          write_back_slot(slot_at_rank(rank));
        add_response(KIND_DONE, 0, '0, 1'b0);
      end
      CMD_FLUSH_LRU: begin
        visits = (int'(cnt) > NSLOTS) ? NSLOTS : int'(cnt);
        for (int j = 0; j < visits; j++)
          write_back_slot(slot_at_rank(NSLOTS - 1 - j));
        add_response(KIND_DONE, 0, '0, 1'b0);
      end
      default: add_response(KIND_ERR, 0, '0, 1'b0);
    endcase

    dirty_count = 0;
    for (int i = 0; i < NSLOTS; i++)
      if (dirty_of[i]) dirty_count++;
    foreach (step_responses[k]) begin
      r             = step_responses[k];
      r.dirty_total = 5'(dirty_count);
      r.last        = (k == step_responses.size() - 1);
      cache_responses.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    cache_result_t want;
    if (!rst_n) begin
      clear_directory();
      cache_responses.delete();
    end else begin
      // The transaction taken at this edge is predicted before any result is checked.
      if (start && !busy)
        directory_step(in_cmd, in_node_address, in_load_wanted, in_slot, in_flush_count);
      if (out_strobe) begin
        if (cache_responses.size() == 0) begin
          $error("unexpected result: kind 0x%0h slot 0x%0h address 0x%0h",
                 out_kind, out_slot_index, out_address_out);
          fail_count++;
        end else begin
          want = cache_responses.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_kind));
          check_field("slot_index", 32'(want.slot_index), 32'(out_slot_index));
          check_field("address_out", want.address_out, out_address_out);
          check_field("read_needed", 32'(want.read_needed), 32'(out_read_needed));
          check_field("dirty_total", 32'(want.dirty_total), 32'(out_dirty_total));
          check_field("last", 32'(want.last), 32'(out_last));
        end
      end
    end
    outstanding = cache_responses.size();
    for (int i = 0; i < NSLOTS; i++)
      slot_tags[i] = tag_of[i];
  end

endmodule

### verif/tb_lru_write_back_node_cache_top.sv
`timescale 1ns / 1ps

module tb_lru_write_back_node_cache_top;
  import lwbc_pkg::*;

  // Command codes the block does not define; each must give an error result.
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
  localparam int         POOL_SIZE        = 24;
  localparam int         RANDOM_ITEMS     = 300;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        start           = 1'b0;
  logic [2:0]  in_cmd          = '0;
  logic [31:0] in_node_address = '0;
  logic        in_load_wanted  = 1'b0;
  logic [3:0]  in_slot         = '0;
  logic [4:0]  in_flush_count  = '0;

  wire         busy;
  wire         out_strobe;
  wire [2:0]   out_kind;
  wire [3:0]   out_slot_index;
  wire [31:0]  out_address_out;
  wire         out_read_needed;
  wire [4:0]   out_dirty_total;
  wire         out_last;

  int               fail_count;
  int               outstanding;
  logic [15:0][31:0] slot_tags;

  logic [31:0] node_pool [POOL_SIZE];
  bit          idle_allowed = 1'b1;

  always #1 clk = ~clk;

  lru_write_back_node_cache_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_node_address (in_node_address),
    .in_load_wanted  (in_load_wanted),
    .in_slot         (in_slot),
    .in_flush_count  (in_flush_count),
    .out_strobe      (out_strobe),
    .out_kind        (out_kind),
    .out_slot_index  (out_slot_index),
    .out_address_out (out_address_out),
    .out_read_needed (out_read_needed),
    .out_dirty_total (out_dirty_total),
    .out_last        (out_last)
  );

  lwbc_result_checker cache_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_node_address (in_node_address),
    .in_load_wanted  (in_load_wanted),
    .in_slot         (in_slot),
    .in_flush_count  (in_flush_count),
    .out_strobe      (out_strobe),
    .out_kind        (out_kind),
    .out_slot_index  (out_slot_index),
    .out_address_out (out_address_out),
    .out_read_needed (out_read_needed),
    .out_dirty_total (out_dirty_total),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .slot_tags       (slot_tags)
  );

  // Called at a falling edge; returns at the falling edge after the transaction is taken.
  task automatic issue(input logic [2:0] cmd, input logic [31:0] addr, input logic load,
                       input logic [3:0] slot, input logic [4:0] cnt);
    while (idle_allowed && $urandom_range(99) < 17) begin
      start           = 1'b0;
      in_cmd          = 3'($urandom);
      in_node_address = $urandom;
      @(negedge clk);
    end
    in_cmd          = cmd;
    in_node_address = addr;
    in_load_wanted  = load;
    in_slot         = slot;
    in_flush_count  = cnt;
    start           = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_node_address();
    int r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 20) return $urandom;
    return node_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  // Prefers a slot that currently holds a tag, so that releases and marks mostly succeed.
  function automatic logic [3:0] pick_live_slot();
    int live[$];
    for (int i = 0; i < 16; i++)
      if (slot_tags[i] != '0) live.push_back(i);
    if (live.size() == 0) return 4'($urandom);
    return 4'(live[$urandom_range(live.size() - 1)]);
  endfunction

  initial begin
    #500000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [3:0] s;
    int         r;
    for (int i = 0; i < POOL_SIZE; i++) begin
      node_pool[i] = $urandom;
      if (node_pool[i] == '0) node_pool[i] = 32'h1;
    end
    node_pool[0] = 32'hFFFF_FFFF;
    node_pool[1] = 32'h0000_0001;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // After reset, misses fill slots from the least recent end: slot 15, then 14.
    issue(CMD_ACCESS, 32'h0, 1'b1, 4'h0, 5'd0);
    issue(CMD_ACCESS, 32'hFFFF_FFFF, 1'b1, 4'hF, 5'd31);
    issue(CMD_ACCESS, 32'h0000_0001, 1'b0, 4'h0, 5'd0);
    issue(CMD_ACCESS, 32'hFFFF_FFFF, 1'b0, 4'h0, 5'd0);
    issue(CMD_MARK, 32'h0, 1'b0, 4'hF, 5'd0);
    issue(CMD_MARK, 32'h0, 1'b0, 4'h0, 5'd0);
    issue(CMD_MARK, 32'h0, 1'b0, 4'hE, 5'd0);
    issue(CMD_RELEASE, 32'h0000_0002, 1'b0, 4'hE, 5'd0);
    issue(CMD_RELEASE, 32'h0, 1'b0, 4'hE, 5'd0);
    // Releasing a dirty slot drops its data without a writeback.
    issue(CMD_RELEASE, 32'h0000_0001, 1'b0, 4'hE, 5'd0);
    issue(CMD_FLUSH_LRU, 32'h0, 1'b0, 4'h0, 5'd0);
    issue(CMD_FLUSH_ALL, 32'h0, 1'b0, 4'h0, 5'd0);
    issue(CMD_MARK, 32'h0, 1'b0, 4'hF, 5'd0);
    issue(CMD_ACCESS, 32'h8000_0000, 1'b1, 4'h0, 5'd0);
    issue(CMD_MARK, 32'h0, 1'b0, 4'hE, 5'd0);
    issue(CMD_FLUSH_LRU, 32'h0, 1'b0, 4'h0, 5'd31);
    issue(CMD_UNUSED_FIRST, 32'hFFFF_FFFF, 1'b1, 4'hF, 5'd31);
    issue(CMD_UNUSED_LAST, 32'h0, 1'b0, 4'h0, 5'd0);
    issue(CMD_ACCESS, 32'h5555_AAAA, 1'b1, 4'h0, 5'd0);
    issue(CMD_MARK, 32'h0, 1'b0, pick_live_slot(), 5'd0);
    issue(CMD_FLUSH_LRU, 32'h0, 1'b0, 4'h0, 5'd16);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_allowed = !(i >= 100 && i < 180);
      r = $urandom_range(99);
      if (r < 50) begin
        issue(CMD_ACCESS, pick_node_address(), 1'($urandom), 4'($urandom), 5'($urandom));
      end else if (r < 72) begin
        s = ($urandom_range(99) < 85) ? pick_live_slot() : 4'($urandom);
        issue(CMD_MARK, $urandom, 1'($urandom), s, 5'($urandom));
      end else if (r < 84) begin
        r = $urandom_range(99);
        s = pick_live_slot();
        if (r < 80)
          issue(CMD_RELEASE, slot_tags[s], 1'($urandom), s, 5'($urandom));
        else if (r < 90)
          issue(CMD_RELEASE, pick_node_address(), 1'($urandom), s, 5'($urandom));
        else
          issue(CMD_RELEASE, pick_node_address(), 1'($urandom), 4'($urandom), 5'($urandom));
      end else if (r < 91) begin
        issue(CMD_FLUSH_LRU, $urandom, 1'($urandom), 4'($urandom),
              ($urandom_range(99) < 70) ? 5'($urandom_range(6)) : 5'($urandom));
      end else if (r < 95) begin
        issue(CMD_FLUSH_ALL, $urandom, 1'($urandom), 4'($urandom), 5'($urandom));
      end else begin
        issue(3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST)), $urandom, 1'($urandom),
              4'($urandom), 5'($urandom));
      end
    end
    start = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
